[hdl/point_in_polygon_test_macros.svh]
// Assertion macros for the point-in-polygon block.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// same-cycle implication
`define PIP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pip assertion failed");

// next-cycle implication
`define PIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pip assertion failed");

`endif

[hdl/pip_pkg.sv]
package pip_pkg;

	localparam int VIDX_WIDTH = 6;
	localparam int CNT_WIDTH  = 7;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TEST  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	typedef struct packed {
		logic clear;
		logic issue;
		logic wrap;
	} edge_ctl_t;

	typedef struct packed {
		logic                 empty;
		logic [CNT_WIDTH-1:0] count;
	} edge_sts_t;

endpackage

[hdl/pip_cell.sv]
module pip_cell #(
	parameter int W = 24
) (
	input  logic                clk,
	input  pip_pkg::cell_ctl_t  ctl,
	input  logic signed [W-1:0] wr_x,
	input  logic signed [W-1:0] wr_y,
	input  logic signed [W-1:0] nb_x,
	input  logic signed [W-1:0] nb_y,
	output logic signed [W-1:0] x_q,
	output logic signed [W-1:0] y_q
);
	import pip_pkg::*;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= wr_x;
			y_q <= wr_y;
		end else if (ctl.shift) begin
			x_q <= nb_x;
			y_q <= nb_y;
		end
	end

endmodule

[hdl/pip_edge.sv]
module pip_edge #(
	parameter int W = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pip_pkg::edge_ctl_t  ctl,
	input  logic signed [W-1:0] pt_x,
	input  logic signed [W-1:0] pt_y,
	input  logic signed [W-1:0] vi_x,
	input  logic signed [W-1:0] vi_y,
	input  logic signed [W-1:0] vn_x,
	input  logic signed [W-1:0] vn_y,
	output pip_pkg::edge_sts_t  sts
);
	import pip_pkg::*;

	logic signed [W-1:0]     px_q, py_q, v0x_q, v0y_q;
	logic signed [W-1:0]     vj_x, vj_y, xa, ya, xb, yb;
	logic                    swap, in_x, in_y;
	logic signed [W:0]       dyp, dx, dye, dxp;
	logic                    v_s1, hit_s1, v_s2, hit_s2;
	logic signed [W:0]       dyp_s1, dx_s1, dye_s1, dxp_s1;
	logic signed [2*W+1:0]   lhs_s2, rhs_s2;
	logic [CNT_WIDTH-1:0]    count_q;

	// edge endpoints, ordered by x
	always_comb begin
		vj_x = ctl.wrap ? v0x_q : vn_x;
		vj_y = ctl.wrap ? v0y_q : vn_y;
		swap = !(vi_x < vj_x);
		xa   = swap ? vj_x : vi_x;
		ya   = swap ? vj_y : vi_y;
		xb   = swap ? vi_x : vj_x;
		yb   = swap ? vi_y : vj_y;
		in_x = (px_q > xa) && (px_q <= xb);
		in_y = (py_q < vi_y) || (py_q <= vj_y);
		dyp  = {py_q[W-1], py_q} - {ya[W-1], ya};
		dx   = {xb[W-1], xb} - {xa[W-1], xa};
		dye  = {yb[W-1], yb} - {ya[W-1], ya};
		dxp  = {px_q[W-1], px_q} - {xa[W-1], xa};
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			px_q  <= pt_x;
			py_q  <= pt_y;
			v0x_q <= vi_x;
			v0y_q <= vi_y;
		end
		hit_s1 <= in_x && in_y;
		dyp_s1 <= dyp;
		dx_s1  <= dx;
		dye_s1 <= dye;
		dxp_s1 <= dxp;
		hit_s2 <= hit_s1;
		lhs_s2 <= dyp_s1 * dx_s1;
		rhs_s2 <= dye_s1 * dxp_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			count_q <= '0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			if (ctl.clear) begin
				count_q <= '0;
			end else if (v_s2 && hit_s2 && (lhs_s2 <= rhs_s2)) begin
				count_q <= count_q + CNT_WIDTH'(1);
			end
		end
	end

	assign sts.empty = !v_s1 && !v_s2;
	assign sts.count = count_q;

endmodule

[hdl/point_in_polygon_test.sv]
// Point-in-polygon test by crossing count.
// Input channel (in_valid/in_stall) carries one word per item. operation
// selects a vertex write (coord_x/coord_y into slot vertex_index, slots at or
// above MAX_VERTICES ignored) or a point test. A write gives no result. A
// test gives one result word on the output channel (out_valid/out_stall):
// crossing_count and its parity as inside_res. cfg_we/cfg_data write
// vertex_count (clamped to MAX_VERTICES); the user is to write it only while
// idle, as the block itself does not enforce this. Vertices sit in a ring
// of cells, one vertex per cell. A test rotates the ring once round, one
// step per cycle, so the head edge unit sees one edge per cycle; a three-stage
// unit (ordering and differences, products, compare and count) follows.
// in_stall stays high while the test runs, until the result is loaded into
// the output register; the ring turns fully round for any vertex count.
// If the receiver stalls, the finished word waits in the output register;
// the block still takes vertex writes, and a further test holds its result
// until the register frees. Reset clears vertex_count and the control state;
// vertex slots are undefined until written.
module point_in_polygon_test #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_WIDTH  = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pip_pkg::CNT_WIDTH-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic [pip_pkg::VIDX_WIDTH-1:0]      vertex_index,
	input  logic signed [COORD_WIDTH-1:0]       coord_x,
	input  logic signed [COORD_WIDTH-1:0]       coord_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                inside_res,
	output logic [pip_pkg::CNT_WIDTH-1:0]       crossing_count
);
	import pip_pkg::*;

	localparam int KW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int CW = (NW > CNT_WIDTH) ? NW : CNT_WIDTH;

	state_t                   state_q, state_d;
	logic [KW-1:0]            k_q;
	logic [CNT_WIDTH-1:0]     vc_q;
	logic [NW-1:0]            n_eff;
	logic                     stall_c, shift, res_load, last_step;
	logic                     acc, test_acc, wr_acc;
	logic                     out_valid_q, inside_q;
	logic [CNT_WIDTH-1:0]     cross_q;
	edge_ctl_t                ectl;
	edge_sts_t                ests;
	logic signed [COORD_WIDTH-1:0] cell_x [MAX_VERTICES];
	logic signed [COORD_WIDTH-1:0] cell_y [MAX_VERTICES];

	assign acc       = in_valid && !stall_c;
	assign test_acc  = acc && (operation == OP_TEST);
	assign wr_acc    = acc && (operation == OP_WRITE);
	assign last_step = (k_q == KW'(MAX_VERTICES - 1));
	assign n_eff     = (CW'(vc_q) > CW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vc_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (test_acc)  state_d = ST_SCAN;
			ST_SCAN:   if (last_step) state_d = ST_FINISH;
			ST_FINISH: if (res_load)  state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		stall_c  = 1'b1;
		shift    = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   stall_c = 1'b0;
			ST_SCAN:   shift = 1'b1;
			ST_FINISH: res_load = ests.empty && (!out_valid_q || !out_stall);
			default:   stall_c = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			vc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				vc_q <= cfg_data;
			end
			if (shift) begin
				k_q <= last_step ? '0 : k_q + KW'(1);
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			cross_q  <= ests.count;
			inside_q <= ests.count[0];
		end
	end

	// ring of vertex cells, rotating towards cell 0
	for (genvar c = 0; c < MAX_VERTICES; c++) begin : g_cell
		localparam int Nxt = (c + 1) % MAX_VERTICES;
		cell_ctl_t cc;
		if (c < 2 ** VIDX_WIDTH) begin : g_wr
			assign cc.load = wr_acc && (vertex_index == VIDX_WIDTH'(c));
		end else begin : g_nowr
			assign cc.load = 1'b0;
		end
		assign cc.shift = shift;
		pip_cell #(.W(COORD_WIDTH)) u_cell (
			.clk  (clk),
			.ctl  (cc),
			.wr_x (coord_x),
			.wr_y (coord_y),
			.nb_x (cell_x[Nxt]),
			.nb_y (cell_y[Nxt]),
			.x_q  (cell_x[c]),
			.y_q  (cell_y[c])
		);
	end

	assign ectl.clear = test_acc;
	assign ectl.issue = shift && (NW'(k_q) < n_eff);
	assign ectl.wrap  = (NW'(k_q) + NW'(1)) == n_eff;

	pip_edge #(.W(COORD_WIDTH)) u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ectl),
		.pt_x   (coord_x),
		.pt_y   (coord_y),
		.vi_x   (cell_x[0]),
		.vi_y   (cell_y[0]),
		.vn_x   (cell_x[1]),
		.vn_y   (cell_y[1]),
		.sts    (ests)
	);

	assign in_stall       = stall_c;
	assign out_valid      = out_valid_q;
	assign inside_res     = inside_q;
	assign crossing_count = cross_q;

endmodule

[hdl/pip_chk.sv]
`include "point_in_polygon_test_macros.svh"

module pip_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          operation,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          inside_res,
	input logic [pip_pkg::CNT_WIDTH-1:0] crossing_count
);
	import pip_pkg::*;

	`PIP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`PIP_ASSERT_NOW(a_parity, clk, arst_n, out_valid, inside_res == crossing_count[0])
	`PIP_ASSERT_NEXT(a_test_busy, clk, arst_n, in_valid && !in_stall && (operation == OP_TEST), in_stall)
	`PIP_ASSERT_NEXT(a_write_silent, clk, arst_n, !out_valid && in_valid && !in_stall && (operation == OP_WRITE), !out_valid)

endmodule

bind point_in_polygon_test pip_chk u_pip_chk (.*);
